FILE: hdl/tpe_pkg.sv
// Package for the tag tracking block: payload structs, operation codes,
// queue entry and controller state types. No dependencies.
package tpe_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int TAG_BITS_DEF  = 31;
  localparam int REG_COUNT_DEF = 16;
  localparam int KIND_W        = 5;
  localparam int FIELD_ADDR_W  = 16;
  localparam int FIELD_REG_W   = 4;
  localparam int FIELD_TAG_W   = 31;
  localparam int SIZE_W        = 2;
  localparam int STATUS_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    K_MEM_ADD = 5'd0,  K_MEM_SET = 5'd1,  K_MEM_CLR = 5'd2,
    K_BLK_ADD = 5'd3,  K_BLK_CLR = 5'd4,  K_REG_ADD = 5'd5,
    K_REG_SET = 5'd6,  K_REG_CLR = 5'd7,  K_MEM_RD  = 5'd8,
    K_REG_RD  = 5'd9,  K_MM_ADD  = 5'd10, K_MM_SET  = 5'd11,
    K_MR_ADD  = 5'd12, K_MR_SET  = 5'd13, K_RM_ADD  = 5'd14,
    K_RM_SET  = 5'd15, K_RR_ADD  = 5'd16, K_RR_SET  = 5'd17
  } kind_t;

  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZEROTAG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADBLK  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [FIELD_ADDR_W-1:0] address;
    logic [FIELD_ADDR_W-1:0] second_address;
    logic [FIELD_REG_W-1:0]  dest_reg;
    logic [FIELD_REG_W-1:0]  src_reg;
    logic [FIELD_TAG_W-1:0]  tag;
    logic [SIZE_W-1:0]       access_size;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [FIELD_TAG_W-1:0] tag_value;
  } out_item_t;

  // classified operation handed from front to back
  typedef enum logic [3:0] {
    OP_NOP, OP_DONE, OP_MEM_WR, OP_BLK, OP_REG_WR, OP_MEM_RD, OP_REG_RD,
    OP_MM, OP_MR, OP_RM, OP_RR
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic                    do_or;   // add (OR) versus set
    logic                    clr;     // clear variant
    logic [STATUS_W-1:0]     status;  // for OP_DONE
    logic [FIELD_ADDR_W-1:0] a;
    logic [FIELD_ADDR_W-1:0] b;
    logic [FIELD_REG_W-1:0]  rd;
    logic [FIELD_REG_W-1:0]  rs;
    logic [FIELD_TAG_W-1:0]  tag;
    logic [2:0]              nbytes;
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_WAIT, S_WR, S_BLK, S_DONE
  } exec_state_t;

endpackage

FILE: hdl/taint_propagation_engine.sv
// Top level of the tag tracking block: queue between front and back end.
// Depends on tpe_pkg, tpe_front, tpe_back.
//
// Usage: drive in_data and raise start; the item is taken on an edge with
// start high and busy low. Exactly one result per item appears on out_data
// for one cycle with out_valid high; the receiver cannot stall it.
// Per item the back end goes straight to the result for register ops,
// register reads, reg-to-reg, rejected items and unused kinds; memory add,
// set, clear and read issue a read, then use the data; mem-to-mem reads the
// source and, when it is tainted, reads and writes the destination; mem-reg
// and reg-mem read per byte (1, 2 or 4 bytes) through the single shadow RAM
// read port, reg-mem stopping after one byte when the source register is
// clean; block ops read, then write, each address; idle follows each item.
// One item is in the back end at a time, one more waits in a one-entry
// queue, so busy rises while the queue is full.
// After reset a clear pass writes zero to all 2^ADDR_BITS shadow entries,
// one per cycle; busy stays high for that pass.
module taint_propagation_engine import tpe_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF,
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);
  cmd_t cls, q_r;
  logic q_valid_r, cmd_ready, clearing, take;

  tpe_front #(.ADDR_BITS(ADDR_BITS), .TAG_BITS(TAG_BITS)) u_front (
    .item(in_data), .cmd(cls)
  );

  assign busy = q_valid_r || clearing;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) q_valid_r <= 1'b0;
    else if (take) q_valid_r <= 1'b1;
    else if (cmd_ready) q_valid_r <= 1'b0;
    if (take) q_r <= cls;
  end

  tpe_back #(.ADDR_BITS(ADDR_BITS), .TAG_BITS(TAG_BITS), .REG_COUNT(REG_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid_r), .cmd(q_r),
    .cmd_ready(cmd_ready), .out_valid(out_valid), .out_data(out_data),
    .clearing(clearing)
  );
endmodule

FILE: hdl/tpe_ram.sv
// Generic simple dual-port RAM with registered read: one read, one write port.
// No dependencies.
module tpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/tpe_front.sv
// Front end: accepts items, masks fields and classifies them into commands.
// Depends on tpe_pkg.
module tpe_front import tpe_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  in_item_t item,
  output cmd_t     cmd
);
  logic [FIELD_TAG_W-1:0]  tagm;
  logic                    tz;
  logic [FIELD_ADDR_W-1:0] am, bm;

  always_comb begin
    tagm = item.tag & FIELD_TAG_W'((64'd1 << TAG_BITS) - 64'd1);
    tz   = (tagm == '0);
    // block bounds compare within the address space
    am   = item.address & FIELD_ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    bm   = item.second_address & FIELD_ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    cmd = '0;
    cmd.a = item.address;
    cmd.b = item.second_address;
    cmd.rd = item.dest_reg;
    cmd.rs = item.src_reg;
    cmd.tag = tagm;
    cmd.nbytes = (item.access_size == 2'd0) ? 3'd1 :
                 (item.access_size == 2'd1) ? 3'd2 : 3'd4;
    cmd.op = OP_NOP;
    unique case (item.kind)
      K_MEM_ADD, K_MEM_SET: begin
        cmd.op = tz ? OP_DONE : OP_MEM_WR;
        cmd.status = ST_ZEROTAG;
        cmd.do_or = (item.kind == K_MEM_ADD);
      end
      K_MEM_CLR: begin
        cmd.op = OP_MEM_WR;
        cmd.clr = 1'b1;
      end
      K_BLK_ADD, K_BLK_CLR: begin
        cmd.clr = (item.kind == K_BLK_CLR);
        if (!cmd.clr && tz) begin
          cmd.op = OP_DONE; cmd.status = ST_ZEROTAG;
        end else if (bm < am) begin
          cmd.op = OP_DONE; cmd.status = ST_BADBLK;
        end else begin
          cmd.op = OP_BLK;
        end
      end
      K_REG_ADD, K_REG_SET: begin
        cmd.op = tz ? OP_DONE : OP_REG_WR;
        cmd.status = tz ? ST_ZEROTAG : ST_NONE;
        cmd.do_or = (item.kind == K_REG_ADD);
      end
      K_REG_CLR: begin
        cmd.op = OP_REG_WR;
        cmd.clr = 1'b1;
      end
      K_MEM_RD: cmd.op = OP_MEM_RD;
      K_REG_RD: cmd.op = OP_REG_RD;
      K_MM_ADD, K_MM_SET: begin
        cmd.op = OP_MM; cmd.do_or = (item.kind == K_MM_ADD);
      end
      K_MR_ADD, K_MR_SET: begin
        cmd.op = OP_MR; cmd.do_or = (item.kind == K_MR_ADD);
      end
      K_RM_ADD, K_RM_SET: begin
        cmd.op = OP_RM; cmd.do_or = (item.kind == K_RM_ADD);
      end
      K_RR_ADD, K_RR_SET: begin
        cmd.op = OP_RR; cmd.do_or = (item.kind == K_RR_ADD);
      end
      default: cmd.op = OP_NOP;
    endcase
  end
endmodule

FILE: hdl/tpe_back.sv
// Back end: executes commands against the shadow RAM and register tags.
// Depends on tpe_pkg and tpe_ram.
module tpe_back import tpe_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF,
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_ready,
  output logic      out_valid,
  output out_item_t out_data,
  output logic      clearing
);
  localparam int DEPTH = 1 << ADDR_BITS;
  localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  exec_state_t state_r, state_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [ADDR_BITS-1:0] ptr_r, ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [TAG_BITS-1:0] acc_r, acc_nxt;
  logic hit_r, hit_nxt;
  logic [TAG_BITS-1:0] regs_r [REG_COUNT];
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic we;
  logic [ADDR_BITS-1:0] waddr, raddr;
  logic [TAG_BITS-1:0] wdata, rdata;

  tpe_ram #(.WIDTH(TAG_BITS), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic rd_ok, rs_ok;
  logic [TAG_BITS-1:0] rs_val, ctag, wr_reg_val, mem_wr_val;
  logic reg_we;
  logic [RW-1:0] rd_i, rs_i;

  assign rd_i  = RW'(cmd_r.rd);
  assign rs_i  = RW'(cmd_r.rs);
  assign rd_ok = 32'(cmd_r.rd) < 32'(REG_COUNT);
  assign rs_ok = 32'(cmd_r.rs) < 32'(REG_COUNT);
  assign rs_val = rs_ok ? regs_r[rs_i] : '0;
  assign ctag = cmd_r.tag[TAG_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (reg_we) regs_r[rd_i] <= wr_reg_val;
    end
    cmd_r <= cmd_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    hit_r <= hit_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    hit_nxt = hit_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    we = 1'b0;
    waddr = ptr_r;
    wdata = '0;
    raddr = ptr_r;
    reg_we = 1'b0;
    wr_reg_val = '0;
    mem_wr_val = cmd_r.do_or ? (rdata | ctag) : ctag;
    cmd_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt = cmd;
          acc_nxt = '0;
          cnt_nxt = '0;
          ptr_nxt = ADDR_BITS'(cmd.a);
          if (cmd.op == OP_MM) ptr_nxt = ADDR_BITS'(cmd.b);
          unique case (cmd.op)
            OP_NOP, OP_DONE, OP_REG_WR, OP_REG_RD, OP_RR: state_nxt = S_DONE;
            OP_BLK: state_nxt = S_BLK;
            default: state_nxt = S_RD;
          endcase
        end
      end
      S_RD: begin
        // read issued at ptr_r; data next cycle
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        unique case (cmd_r.op)
          OP_MEM_RD: begin
            acc_nxt = rdata;
            state_nxt = S_DONE;
          end
          OP_MEM_WR: begin
            hit_nxt = (rdata != '0);
            we = 1'b1;
            wdata = cmd_r.clr ? '0 : mem_wr_val;
            state_nxt = S_DONE;
          end
          OP_MM: begin
            acc_nxt = rdata;
            ptr_nxt = ADDR_BITS'(cmd_r.a);
            state_nxt = (rdata != '0) ? S_WR : S_DONE;
          end
          OP_MR: begin
            acc_nxt = acc_r | rdata;
            cnt_nxt = cnt_r + 3'd1;
            ptr_nxt = ptr_r + 1'b1;
            state_nxt = (cnt_r + 3'd1 == cmd_r.nbytes) ? S_DONE : S_RD;
          end
          default: begin
            // reg-to-mem: read-modify-write one byte
            we = rs_val != '0;
            wdata = cmd_r.do_or ? (rdata | rs_val) : rs_val;
            cnt_nxt = cnt_r + 3'd1;
            ptr_nxt = ptr_r + 1'b1;
            state_nxt = (rs_val == '0 || cnt_r + 3'd1 == cmd_r.nbytes) ?
                        S_DONE : S_RD;
          end
        endcase
      end
      S_WR: begin
        // mem-to-mem destination: read issued here, write next
        state_nxt = S_BLK;
        raddr = ptr_r;
      end
      S_BLK: begin
        if (cmd_r.op == OP_MM) begin
          we = 1'b1;
          wdata = cmd_r.do_or ? (rdata | acc_r) : acc_r;
          state_nxt = S_DONE;
        end else begin
          // block: read current, write next cycle via S_WAIT-like step
          raddr = ptr_r;
          we = cnt_r[0];
          waddr = ptr_r;
          wdata = cmd_r.clr ? '0 : (rdata | ctag);
          cnt_nxt = {2'b0, ~cnt_r[0]};
          if (cnt_r[0]) begin
            ptr_nxt = ptr_r + 1'b1;
            if (ptr_r == ADDR_BITS'(cmd_r.b)) state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_nxt = '0;
        unique case (cmd_r.op)
          OP_DONE: out_nxt.status = cmd_r.status;
          OP_MEM_WR: out_nxt.status = hit_r ? ST_HIT : ST_NONE;
          OP_REG_WR: begin
            reg_we = rd_ok;
            wr_reg_val = cmd_r.clr ? '0 :
                         (cmd_r.do_or ? (regs_r[rd_i] | ctag) : ctag);
          end
          OP_MEM_RD: begin
            out_nxt.tag_value = FIELD_TAG_W'(acc_r);
            out_nxt.status = (acc_r != '0) ? ST_HIT : ST_NONE;
          end
          OP_REG_RD: begin
            out_nxt.tag_value = FIELD_TAG_W'(rs_val);
            out_nxt.status = (rs_val != '0) ? ST_HIT : ST_NONE;
          end
          OP_MM: out_nxt.status = (acc_r != '0) ? ST_HIT : ST_NONE;
          OP_MR: begin
            reg_we = rd_ok && acc_r != '0;
            wr_reg_val = cmd_r.do_or ? (regs_r[rd_i] | acc_r) : acc_r;
            out_nxt.status = (acc_r != '0) ? ST_HIT : ST_NONE;
          end
          OP_RM: out_nxt.status = (rs_val != '0) ? ST_HIT : ST_NONE;
          OP_RR: begin
            reg_we = rd_ok && rs_val != '0;
            wr_reg_val = cmd_r.do_or ? (regs_r[rd_i] | rs_val) : rs_val;
            out_nxt.status = (rs_val != '0) ? ST_HIT : ST_NONE;
          end
          default: out_nxt.status = ST_NONE;
        endcase
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign clearing  = (state_r == S_CLEAR);

  ast_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid_nxt) else $error("result during clear pass");
  ast_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  ast_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid) else $error("lost result");
endmodule

FILE: tb/testbench.sv
// Testbench for taint_propagation_engine: random and directed tag operations,
// checked against an in-bench shadow memory and register tag predictor.
// Depends on tpe_pkg and the taint_propagation_engine RTL.
module testbench;
  import tpe_pkg::*;

  localparam int NUM_RANDOM = 550;

  class tag_scoreboard;
    logic [30:0] shadow_mem [int];
    logic [30:0] reg_tags [16];
    out_item_t   pending [$];
    int          errors;

    function new();
      errors = 0;
      foreach (reg_tags[i]) reg_tags[i] = '0;
    endfunction

    function logic [30:0] mem_rd(logic [15:0] a);
      return shadow_mem.exists(a) ? shadow_mem[a] : '0;
    endfunction

    // compute the result of one accepted transaction and update the tag state
    function void note_transaction(in_item_t t);
      out_item_t   r;
      logic [30:0] src;
      logic [15:0] a;
      int          n;
      a   = t.address;
      src = '0;
      r.status    = ST_NONE;
      r.tag_value = '0;
      n = (t.access_size == 0) ? 1 : (t.access_size == 1) ? 2 : 4;
      case (t.kind)
        K_MEM_ADD, K_MEM_SET: begin
          if (t.tag == 0) r.status = ST_ZEROTAG;
          else begin
            r.status = (mem_rd(a) != 0) ? ST_HIT : ST_NONE;
            shadow_mem[a] = (t.kind == K_MEM_ADD) ? (mem_rd(a) | t.tag) : t.tag;
          end
        end
        K_MEM_CLR: begin
          r.status = (mem_rd(a) != 0) ? ST_HIT : ST_NONE;
          shadow_mem[a] = '0;
        end
        K_BLK_ADD, K_BLK_CLR: begin
          if (t.kind == K_BLK_ADD && t.tag == 0) r.status = ST_ZEROTAG;
          else if (t.second_address < t.address) r.status = ST_BADBLK;
          else begin
            for (int i = t.address; i <= t.second_address; i++)
              shadow_mem[i] = (t.kind == K_BLK_ADD) ? (mem_rd(16'(i)) | t.tag) : '0;
          end
        end
        K_REG_ADD, K_REG_SET: begin
          if (t.tag == 0) r.status = ST_ZEROTAG;
          else reg_tags[t.dest_reg] = (t.kind == K_REG_ADD) ?
                                      (reg_tags[t.dest_reg] | t.tag) : t.tag;
        end
        K_REG_CLR: reg_tags[t.dest_reg] = '0;
        K_MEM_RD: begin
          r.tag_value = mem_rd(a);
          r.status = (r.tag_value != 0) ? ST_HIT : ST_NONE;
        end
        K_REG_RD: begin
          r.tag_value = reg_tags[t.src_reg];
          r.status = (r.tag_value != 0) ? ST_HIT : ST_NONE;
        end
        K_MM_ADD, K_MM_SET: begin
          src = mem_rd(t.second_address);
          if (src != 0) begin
            shadow_mem[a] = (t.kind == K_MM_ADD) ? (mem_rd(a) | src) : src;
            r.status = ST_HIT;
          end
        end
        K_MR_ADD, K_MR_SET: begin
          for (int i = 0; i < n; i++) src |= mem_rd(a + 16'(i));
          if (src != 0) begin
            reg_tags[t.dest_reg] = (t.kind == K_MR_ADD) ?
                                   (reg_tags[t.dest_reg] | src) : src;
            r.status = ST_HIT;
          end
        end
        K_RM_ADD, K_RM_SET: begin
          src = reg_tags[t.src_reg];
          if (src != 0) begin
            for (int i = 0; i < n; i++)
              shadow_mem[a + 16'(i)] = (t.kind == K_RM_ADD) ?
                                       (mem_rd(a + 16'(i)) | src) : src;
            r.status = ST_HIT;
          end
        end
        K_RR_ADD, K_RR_SET: begin
          src = reg_tags[t.src_reg];
          if (src != 0) begin
            reg_tags[t.dest_reg] = (t.kind == K_RR_ADD) ?
                                   (reg_tags[t.dest_reg] | src) : src;
            r.status = ST_HIT;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status got %0d exp %0d", got.status, exp.status));
      if (got.tag_value !== exp.tag_value)
        report($sformatf("tag_value got %h exp %h", got.tag_value, exp.tag_value));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  tag_scoreboard tags_sb;
  bit            quiet_tail;
  logic [15:0]   hot_addr [8];

  taint_propagation_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout: covers the clear pass plus slow block operations.
  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tags_sb.check_result(out_data);
  end

  // Hold start until the transaction is taken; a gap or a drain drops it.
  task send(in_item_t t);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= t;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    tags_sb.note_transaction(t);
    @(negedge clk);
  endtask

  task drain();
    start <= 1'b0;
    @(negedge clk);
    while (tags_sb.pending.size() != 0) @(negedge clk);
  endtask

  function in_item_t make_item(logic [KIND_W-1:0] k, logic [15:0] a, logic [15:0] b,
                               logic [3:0] rd, logic [3:0] rs, logic [30:0] tg,
                               logic [1:0] sz);
    in_item_t t;
    t.kind = k; t.address = a; t.second_address = b; t.dest_reg = rd;
    t.src_reg = rs; t.tag = tg; t.access_size = sz;
    return t;
  endfunction

  function in_item_t random_item();
    in_item_t t;
    int       sel;
    t.kind           = kind_t'($urandom_range(0, 17));
    sel              = $urandom_range(0, 9);
    t.address        = (sel < 7) ? hot_addr[$urandom_range(0, 7)] + 16'($urandom_range(0, 3))
                                 : 16'($urandom);
    t.second_address = (sel < 7) ? hot_addr[$urandom_range(0, 7)] + 16'($urandom_range(0, 3))
                                 : 16'($urandom);
    t.dest_reg       = 4'($urandom);
    t.src_reg        = 4'($urandom);
    t.tag            = ($urandom_range(0, 15) == 0) ? '0 : 31'($urandom);
    t.access_size    = 2'($urandom);
    // keep blocks short: end near start
    if (t.kind == K_BLK_ADD || t.kind == K_BLK_CLR)
      t.second_address = ($urandom_range(0, 7) == 0) ? t.address - 16'($urandom_range(1, 5))
                                                     : t.address + 16'($urandom_range(0, 12));
    if ($urandom_range(0, 40) == 0) t.kind = 5'($urandom_range(18, 31));
    return t;
  endfunction

  initial begin
    tags_sb    = new();
    quiet_tail = 1'b0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    foreach (hot_addr[i]) hot_addr[i] = 16'($urandom);
    hot_addr[0] = 16'hFFFE;
    hot_addr[1] = 16'h0000;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every operation, wraps, zero tags, bad blocks
    send(make_item(K_MEM_RD,  16'h0000, 16'h0, 4'd0, 4'd0, 31'h0, 2'd0));
    send(make_item(K_MEM_ADD, 16'hFFFF, 16'h0, 4'd0, 4'd0, 31'h7FFFFFFF, 2'd0));
    send(make_item(K_MEM_ADD, 16'hFFFF, 16'h0, 4'd0, 4'd0, 31'h1, 2'd0));
    send(make_item(K_MEM_SET, 16'h0000, 16'h0, 4'd0, 4'd0, 31'h40000000, 2'd0));
    send(make_item(K_MEM_SET, 16'h0001, 16'h0, 4'd0, 4'd0, 31'h0, 2'd0));
    send(make_item(K_MR_ADD,  16'hFFFF, 16'h0, 4'd15, 4'd0, 31'h0, 2'd3));
    send(make_item(K_REG_RD,  16'h0, 16'h0, 4'd0, 4'd15, 31'h0, 2'd0));
    send(make_item(K_RM_SET,  16'hFFFD, 16'h0, 4'd0, 4'd15, 31'h0, 2'd2));
    send(make_item(K_MEM_RD,  16'h0000, 16'h0, 4'd0, 4'd0, 31'h0, 2'd0));
    send(make_item(K_MEM_CLR, 16'hFFFF, 16'h0, 4'd0, 4'd0, 31'h0, 2'd0));
    send(make_item(K_MEM_CLR, 16'hFFFF, 16'h0, 4'd0, 4'd0, 31'h0, 2'd0));
    send(make_item(K_BLK_ADD, 16'h0010, 16'h0014, 4'd0, 4'd0, 31'h5, 2'd0));
    send(make_item(K_BLK_ADD, 16'h0010, 16'h0014, 4'd0, 4'd0, 31'h0, 2'd0));
    send(make_item(K_BLK_CLR, 16'h0014, 16'h0010, 4'd0, 4'd0, 31'h0, 2'd0));
    send(make_item(K_BLK_CLR, 16'h0012, 16'h0012, 4'd0, 4'd0, 31'h0, 2'd0));
    send(make_item(K_REG_ADD, 16'h0, 16'h0, 4'd3, 4'd0, 31'h2AAAAAAA, 2'd0));
    send(make_item(K_REG_SET, 16'h0, 16'h0, 4'd4, 4'd0, 31'h0, 2'd0));
    send(make_item(K_RR_ADD,  16'h0, 16'h0, 4'd4, 4'd3, 31'h0, 2'd0));
    send(make_item(K_RR_SET,  16'h0, 16'h0, 4'd5, 4'd7, 31'h0, 2'd0));
    send(make_item(K_MM_ADD,  16'h0020, 16'h0010, 4'd0, 4'd0, 31'h0, 2'd0));
    send(make_item(K_MM_SET,  16'h0021, 16'h0012, 4'd0, 4'd0, 31'h0, 2'd0));
    send(make_item(K_MR_SET,  16'h0013, 16'h0, 4'd6, 4'd0, 31'h0, 2'd1));
    send(make_item(K_RM_ADD,  16'h0030, 16'h0, 4'd0, 4'd6, 31'h0, 2'd0));
    send(make_item(K_REG_CLR, 16'h0, 16'h0, 4'd3, 4'd0, 31'h0, 2'd0));
    send(make_item(5'd31,     16'hFFFF, 16'hFFFF, 4'd15, 4'd15, 31'h7FFFFFFF, 2'd3));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) drain();
      if (n == NUM_RANDOM - 60) quiet_tail = 1'b1;
      send(random_item());
    end

    drain();
    repeat (50) @(negedge clk);
    if (tags_sb.errors == 0 && tags_sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/tpe_pkg.sv
hdl/tpe_ram.sv
hdl/tpe_front.sv
hdl/tpe_back.sv
hdl/taint_propagation_engine.sv
tb/testbench.sv
